FILE: rtl/block_rms_level_silence_stop_assert.svh
// Assertion macros shared by the RMS level meter RTL.
`ifndef BLOCK_RMS_LEVEL_SILENCE_STOP_ASSERT_SVH
`define BLOCK_RMS_LEVEL_SILENCE_STOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define RMSL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmsl: assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define RMSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmsl: assertion failed");
`else
`define RMSL_ASSERT_IMPL(label, ante, cons)
`define RMSL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/rmsl_pkg.sv
// Shared constants, codes and types of the RMS level meter.
package rmsl_pkg;

  // default parameter values
  localparam int BLOCK_MAX_DEF   = 4096;
  localparam int SAMPLE_RATE_DEF = 48000;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 7;
  localparam int MS_W     = 32;
  localparam int CAUSE_W  = 2;
  localparam int SSEC_W   = 12;
  localparam int SLVL_W   = 7;
  localparam int DUR_W    = 16;
  localparam int EXIST_W  = 32;
  localparam int TOT_W    = 40;
  localparam int ALL_W    = 41;
  localparam int SIL_W    = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_SEC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXISTING    = 2'd3;

  localparam logic [SLVL_W-1:0] SLVL_RESET = 7'd5;
  localparam logic [DUR_W-1:0]  DUR_RESET  = 16'd60;

  // stop causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_SILENCE  = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_DURATION = 2'd2;

  // result word layout
  localparam int OUT_W     = 48;
  localparam int VOL_LSB   = 0;
  localparam int MS_LSB    = VOL_LSB + VOL_W;
  localparam int STOP_BIT  = MS_LSB + MS_W;
  localparam int CAUSE_LSB = STOP_BIT + 1;
  localparam int USED_W    = CAUSE_LSB + CAUSE_W;

  // serial squarer
  localparam int SQ_STEPS  = SAMPLE_W;
  localparam int SQ_CNT_W  = 5;
  localparam int MCAND_W   = 2 * SAMPLE_W - 1;
  localparam int SQUARE_W  = 2 * SAMPLE_W - 2;

  // level: largest v with v^2 <= (90000 * mean) >> 30, clamped to 100
  localparam int MEAN_W     = 31;
  localparam int LEVEL_K_W  = 17;
  localparam logic [LEVEL_K_W-1:0] LEVEL_K = 17'd90000;
  localparam int PROD_SHIFT = 30;
  localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

  localparam int MS_PER_S  = 1000;
  localparam int DUR_MS_W  = DUR_W + 10;

  typedef struct packed {
    logic start;
    logic clear;
  } sq_ctl_t;

endpackage

FILE: rtl/block_rms_level_silence_stop.sv
// Top level of the block RMS level meter with silence and duration stop.
//
//   port group  | dir | word                                   | taken when
//   s_*         | in  | tdata: sample[15:0]; tlast: block end  | s_tvalid & s_tready
//   m_*         | out | volume, elapsed_ms, stop, stop_cause    | m_tvalid & m_tready
//   cfg_*       | in  | cfg_data to register cfg_index         | cfg_we
//
// A sample is taken in its accept cycle and then squared by the bit-serial squarer.
// A block end then runs the serial divider for the mean (DIV_W = max(30 + clog2(BLOCK_MAX+1), 41),
// 43 at the defaults), the root unit, and a second divider pass for the elapsed time.
// Reset is synchronous; there is no clearing pass.
// The result register frees the input side; a second block end waits only while the
// previous result is still held. After a stop, samples are taken and dropped.
module block_rms_level_silence_stop
  import rmsl_pkg::*;
#(
  parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // sample[15:0]
  input  logic                  s_tlast,   // last_in_block
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // volume[6:0], elapsed_ms[38:7], stop[39], stop_cause[41:40], zero[47:42]
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "block_rms_level_silence_stop_assert.svh"

  localparam int CNT_W   = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W   = SQUARE_W + CNT_W;
  localparam int PER_MS0 = SAMPLE_RATE / MS_PER_S;
  localparam int PER_MS  = (PER_MS0 == 0) ? 1 : PER_MS0;
  localparam int PMS_W   = $clog2(PER_MS + 1);
  localparam int DIV_W   = (SUM_W > ALL_W) ? SUM_W : ALL_W;
  localparam int DVS_W   = (CNT_W > PMS_W) ? CNT_W : PMS_W;
  localparam int THR_W   = SSEC_W + $clog2(SAMPLE_RATE + 1);
  localparam int CMP_W   = (THR_W > SIL_W) ? THR_W : SIL_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ      = 4'd1;
  localparam logic [3:0] S_MEAN_GO = 4'd2;
  localparam logic [3:0] S_MEAN    = 4'd3;
  localparam logic [3:0] S_LVL_GO  = 4'd4;
  localparam logic [3:0] S_LVL     = 4'd5;
  localparam logic [3:0] S_SIL     = 4'd6;
  localparam logic [3:0] S_MS_GO   = 4'd7;
  localparam logic [3:0] S_MS      = 4'd8;
  localparam logic [3:0] S_LIM     = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  // configuration
  logic [SSEC_W-1:0]  ssec;
  logic [SLVL_W-1:0]  slvl;
  logic [DUR_W-1:0]   dur;
  logic [EXIST_W-1:0] existing;
  logic [THR_W-1:0]   sil_thr;
  logic [DUR_MS_W-1:0] dur_ms;

  // control and running state
  logic [3:0]          st;
  logic [CNT_W-1:0]    bcnt;
  logic [CNT_W-1:0]    bcnt_next;
  logic [CNT_W-1:0]    n;
  logic                blk_end;
  logic [TOT_W-1:0]    total;
  logic [SIL_W-1:0]    sil;
  logic [SIL_W:0]      sil_sum;
  logic                stopped;
  logic [DIV_W-1:0]    all_r;
  logic [MS_W-1:0]     ms_r;
  logic [MS_W-1:0]     ms_sat;
  logic [CAUSE_W-1:0]  cause_r;
  logic                sil_hit;
  logic                dur_hit;
  logic                accept;

  // unit connections
  sq_ctl_t             sq_ctl;
  logic [SAMPLE_W-1:0] mag;
  logic                sq_busy;
  logic [SUM_W-1:0]    sum;
  logic                div_start;
  logic [DIV_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic                div_busy;
  logic [DIV_W-1:0]    quot;
  logic                lvl_start;
  logic                lvl_busy;
  logic [VOL_W-1:0]    vol;

  assign s_tready  = (st == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign mag       = s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
  assign bcnt_next = bcnt + 1'b1;

  assign sq_ctl.start = accept && !stopped;
  assign sq_ctl.clear = (st == S_MEAN_GO);
  assign div_start    = (st == S_MEAN_GO) || (st == S_MS_GO);
  assign div_dvd      = (st == S_MS_GO) ? all_r : DIV_W'(sum);
  assign div_dvs      = (st == S_MS_GO) ? DVS_W'(PER_MS) : DVS_W'(n);
  assign lvl_start    = (st == S_LVL_GO);

  assign sil_sum = (SIL_W+1)'(sil) + (SIL_W+1)'(n);
  assign ms_sat  = (|quot[DIV_W-1:MS_W]) ? '1 : quot[MS_W-1:0];
  assign sil_hit = (ssec != '0) && (CMP_W'(sil) > CMP_W'(sil_thr));
  assign dur_hit = (ms_sat >= MS_W'(dur_ms));

  rmsl_sqacc #(
    .SUM_W (SUM_W)
  ) u_sqacc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sq_ctl),
    .mag  (mag),
    .busy (sq_busy),
    .sum  (sum)
  );

  rmsl_div #(
    .DVD_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (quot)
  );

  rmsl_level u_level (
    .clk    (clk),
    .rst    (rst),
    .start  (lvl_start),
    .mean   (quot[MEAN_W-1:0]),
    .busy   (lvl_busy),
    .volume (vol)
  );

  // configuration registers and the limits derived from them
  always_ff @(posedge clk) begin
    if (rst) begin
      ssec     <= '0;
      slvl     <= SLVL_RESET;
      dur      <= DUR_RESET;
      existing <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SILENCE_SEC: ssec     <= cfg_data[SSEC_W-1:0];
        REG_SILENCE_LVL: slvl     <= cfg_data[SLVL_W-1:0];
        REG_DURATION:    dur      <= cfg_data[DUR_W-1:0];
        REG_EXISTING:    existing <= cfg_data[EXIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sil_thr <= THR_W'(ssec) * THR_W'(SAMPLE_RATE);
    dur_ms  <= DUR_MS_W'(dur) * DUR_MS_W'(MS_PER_S);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      bcnt     <= '0;
      blk_end  <= 1'b0;
      total    <= '0;
      sil      <= '0;
      stopped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // free the result register; S_OUT reloads it on its own
      if (m_tvalid && m_tready && (st != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          // after a stop, drop the word
          if (accept && !stopped) begin
            n <= bcnt_next;
            if (s_tlast || bcnt_next == CNT_W'(BLOCK_MAX)) begin
              blk_end <= 1'b1;
              bcnt    <= '0;
            end else begin
              blk_end <= 1'b0;
              bcnt    <= bcnt_next;
            end
            if (total != '1) begin
              total <= total + 1'b1;
            end
            st <= S_SQ;
          end
        end
        S_SQ: begin
          if (!sq_busy) begin
            st <= blk_end ? S_MEAN_GO : S_IDLE;
          end
        end
        S_MEAN_GO: st <= S_MEAN;
        S_MEAN: begin
          if (!div_busy) begin
            st <= S_LVL_GO;
          end
        end
        S_LVL_GO: st <= S_LVL;
        S_LVL: begin
          if (!lvl_busy) begin
            st <= S_SIL;
          end
        end
        S_SIL: begin
          if (vol < slvl) begin
            sil <= sil_sum[SIL_W] ? '1 : sil_sum[SIL_W-1:0];
          end else begin
            sil <= '0;
          end
          // round up: add per_ms - 1 before dividing
          all_r <= DIV_W'(total) + DIV_W'(existing) + DIV_W'(PER_MS - 1);
          st    <= S_MS_GO;
        end
        S_MS_GO: st <= S_MS;
        S_MS: begin
          if (!div_busy) begin
            st <= S_LIM;
          end
        end
        S_LIM: begin
          ms_r <= ms_sat;
          if (sil_hit) begin
            cause_r <= CAUSE_SILENCE;
          end else if (dur_hit) begin
            cause_r <= CAUSE_DURATION;
          end else begin
            cause_r <= CAUSE_NONE;
          end
          st <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_W-USED_W){1'b0}}, cause_r, (cause_r != CAUSE_NONE),
                         ms_r, vol};
            if (cause_r != CAUSE_NONE) begin
              stopped <= 1'b1;
            end
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `RMSL_ASSERT_IMPL(a_stop_with_result, $rose(stopped), m_tvalid && m_tdata[STOP_BIT])
  `RMSL_ASSERT_IMPL(a_no_square_after_stop, stopped, !sq_busy)
  `RMSL_ASSERT_IMPL(a_div_in_div_states, div_busy, (st == S_MEAN) || (st == S_MS))
  `RMSL_ASSERT_NEXT(a_result_loaded, (st == S_OUT) && (!m_tvalid || m_tready), m_tvalid && (st == S_IDLE))

endmodule

FILE: rtl/rmsl_sqacc.sv
// Bit-serial square-and-accumulate of sample magnitudes into the block sum.
module rmsl_sqacc
  import rmsl_pkg::*;
#(
  parameter int SUM_W = 43
) (
  input  logic                clk,
  input  logic                rst,
  input  sq_ctl_t             ctl,
  input  logic [SAMPLE_W-1:0] mag,
  output logic                busy,
  output logic [SUM_W-1:0]    sum
);

  logic [MCAND_W-1:0]  mcand;
  logic [SAMPLE_W-1:0] mplier;
  logic [SQ_CNT_W-1:0] cnt;

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sum <= '0;
    end else if (ctl.start) begin
      mcand  <= MCAND_W'(mag);
      mplier <= mag;
      cnt    <= SQ_CNT_W'(SQ_STEPS);
    end else if (ctl.clear) begin
      sum <= '0;
    end else if (busy) begin
      // add the shifted multiplicand where the multiplier bit is set
      if (mplier[0]) begin
        sum <= sum + SUM_W'(mcand);
      end
      mcand  <= {mcand[MCAND_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[SAMPLE_W-1:1]};
      cnt    <= cnt - 1'b1;
    end
  end

endmodule

FILE: rtl/rmsl_div.sv
// Restoring divider, one quotient bit per cycle, shared by mean and elapsed time.
module rmsl_div
  import rmsl_pkg::*;
#(
  parameter int DVD_W = 43,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign busy  = (cnt != '0);
  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      cnt      <= CNT_W'(DVD_W);
    end else if (busy) begin
      // shift the dividend out the top, the quotient bit in at the bottom
      rem      <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

FILE: rtl/rmsl_level.sv
// Block volume: scale the mean square, then a bit-by-bit integer square root.
module rmsl_level
  import rmsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MEAN_W-1:0] mean,
  output logic              busy,
  output logic [VOL_W-1:0]  volume
);

  localparam int PROD_W = MEAN_W + LEVEL_K_W;
  localparam int T_W    = PROD_W - PROD_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [VOL_W-1:0]  mask;
  logic [VOL_W-1:0]  root;
  logic [VOL_W-1:0]  cand;
  logic [T_W-1:0]    target;
  logic [T_W-1:0]    cand_sq;

  assign busy    = (mask != '0);
  assign target  = prod[PROD_W-1:PROD_SHIFT];
  assign cand    = root | mask;
  assign cand_sq = T_W'(cand) * T_W'(cand);
  assign volume  = (root > VOL_MAX) ? VOL_MAX : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (start) begin
      prod <= PROD_W'(mean) * PROD_W'(LEVEL_K);
      root <= '0;
      mask <= {1'b1, {(VOL_W-1){1'b0}}};
    end else if (busy) begin
      // keep the trial bit while its square still fits
      if (cand_sq <= target) begin
        root <= cand;
      end
      mask <= {1'b0, mask[VOL_W-1:1]};
    end
  end

endmodule
